FILE: design/bmida_pkg.sv
// ============================================================================
// bmida_pkg
// Shared types and constants of the two-level bitmap ID allocator.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package bmida_pkg;

    // IDs per bucket and the width of a bucket's free counter (holds 0..256).
    localparam int BUCKET_IDS = 256;
    localparam int CNT_W      = 9;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_NOT_TAKEN = 2'd2
    } t_status;

    typedef struct packed {
        t_op         op;
        logic [15:0] release_id;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] given_id;
    } t_out_item;

    // Update of one bucket's summary flag after a bitmap write.
    typedef struct packed {
        logic       en;
        logic [7:0] bucket;
        logic       has_free;
    } t_sum_upd;

endpackage

`default_nettype wire

FILE: design/bmida_ram.sv
// ============================================================================
// bmida_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bmida_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: design/bmida_bsum.sv
// ============================================================================
// bmida_bsum
// Per-bucket free flags and a registered two-level first-free-bucket search.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bmida_bsum #(
    parameter int NUM_BUCKETS = 256
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire bmida_pkg::t_sum_upd i_upd,
    input  wire logic                i_snap,
    input  wire logic [7:0]          i_recent,
    output logic                     o_recent_free,
    output logic                     o_any_free,
    output logic [7:0]               o_first_bkt
);

    localparam int GRP   = 16;
    localparam int GI_W  = $clog2(GRP);
    localparam int NGRP  = (NUM_BUCKETS + GRP - 1) / GRP;
    localparam int PAD   = NGRP * GRP;
    localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

    logic [NUM_BUCKETS-1:0] r_free;
    logic [PAD-1:0]         w_pad;
    logic [NGRP-1:0]        w_grp_any;
    logic [GI_W-1:0]        w_grp_idx [NGRP];
    logic [NGRP-1:0]        r_grp_any;
    logic [GI_W-1:0]        r_grp_idx [NGRP];
    logic [7:0]             w_first;

    // Every bucket starts with free IDs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
        end else if (i_upd.en) begin
            r_free[i_upd.bucket[BKT_W-1:0]] <= i_upd.has_free;
        end
    end

    always_comb begin
        w_pad = PAD'(r_free);
        for (int g = 0; g < NGRP; g++) begin
            w_grp_any[g] = |w_pad[g*GRP +: GRP];
            w_grp_idx[g] = '0;
            for (int j = GRP - 1; j >= 0; j--) begin
                if (w_pad[g*GRP + j]) begin
                    w_grp_idx[g] = GI_W'(j);
                end
            end
        end
    end

    // The first level is registered when an allocate is taken in.
    always_ff @(posedge i_clk) begin
        if (i_snap) begin
            r_grp_any <= w_grp_any;
            for (int g = 0; g < NGRP; g++) begin
                r_grp_idx[g] <= w_grp_idx[g];
            end
        end
    end

    always_comb begin
        w_first = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                w_first = 8'(g * GRP) + 8'(r_grp_idx[g]);
            end
        end
    end

    assign o_any_free    = |r_grp_any;
    assign o_first_bkt   = w_first;
    assign o_recent_free = r_free[i_recent[BKT_W-1:0]];

endmodule

`default_nettype wire

FILE: design/two_level_bitmap_id_allocator.sv
// ============================================================================
// two_level_bitmap_id_allocator
// Allocates and releases 16-bit IDs from per-bucket free bitmaps in RAM.
// Each item walks bucket record read, bitmap word read and write-back in
// sequence, an allocate after a bucket pick; a release with an out-of-range
// ID skips to the result. A new item is taken only after the last one's
// result is registered, so the input stalls while an item is in flight.
// Reset is synchronous; no clearing pass is needed: per-bucket valid flags
// and per-word written bits stand in for the reset contents of both RAMs.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module two_level_bitmap_id_allocator #(
    parameter int NUM_BUCKETS = 256,
    parameter int WORD_BITS   = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire bmida_pkg::t_in_item  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output bmida_pkg::t_out_item      o_out_data
);

    localparam int WPB       = bmida_pkg::BUCKET_IDS / WORD_BITS;
    localparam int WIDX_W    = (WPB > 1) ? $clog2(WPB) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int MAP_DEPTH = NUM_BUCKETS * WPB;
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int BKT_W     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int CNT_W     = bmida_pkg::CNT_W;
    localparam int REC_W     = 2 * WPB + WIDX_W + CNT_W;
    localparam logic [WIDX_W:0]    HINT_LIM = (WIDX_W + 1)'(WPB);
    localparam logic [CNT_W-1:0]   CNT_MAX  = CNT_W'(bmida_pkg::BUCKET_IDS);
    localparam logic [WORD_BITS-1:0] WORD_ONE = WORD_BITS'(1);

    typedef struct packed {
        logic [WPB-1:0]    written;
        logic [WPB-1:0]    nz;
        logic [WIDX_W-1:0] hint;
        logic [CNT_W-1:0]  cnt;
    } t_rec;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_REC,
        S_MAP,
        S_UPD,
        S_RES
    } t_state;

    t_state                r_state;
    bmida_pkg::t_op        r_op;
    logic [7:0]            r_bkt;
    logic [WIDX_W-1:0]     r_w;
    logic [BIT_W-1:0]      r_bit;
    logic [7:0]            r_recent;
    logic [NUM_BUCKETS-1:0] r_rec_vld;
    t_rec                  r_rec;
    bmida_pkg::t_out_item  r_res;
    logic                  r_out_valid;
    bmida_pkg::t_out_item  r_out;

    logic                  w_accept;
    logic [WIDX_W-1:0]     w_rel_w;
    logic [8:0]            w_rel_bit9;
    logic                  w_rel_bad;

    logic [REC_W-1:0]      w_rec_rd_data;
    t_rec                  w_rec_reset;
    t_rec                  w_rec_eff;
    logic                  w_hint_ok;
    logic [WIDX_W-1:0]     w_first_w;
    logic [WIDX_W-1:0]     w_sel_w;
    logic [MAP_AW-1:0]     w_map_rd_addr;
    logic [MAP_AW-1:0]     w_map_wr_addr;

    logic [WORD_BITS-1:0]  w_map_rd_data;
    logic [WORD_BITS-1:0]  w_word;
    logic [BIT_W-1:0]      w_low;
    logic [WORD_BITS-1:0]  w_rel_mask;
    logic                  w_was_free;
    logic [WORD_BITS-1:0]  w_new_word;
    t_rec                  w_new_rec;
    logic                  w_do_write;
    logic [8:0]            w_slot;
    bmida_pkg::t_out_item  w_res;
    logic                  w_out_free;
    logic                  w_load;

    logic                  w_recent_free;
    logic                  w_any_free;
    logic [7:0]            w_first_bkt;
    bmida_pkg::t_sum_upd   w_sum_upd;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = ((r_state == S_UPD) || (r_state == S_RES)) && w_out_free;

    // Split a released ID's slot into word index and bit position.
    always_comb begin
        w_rel_w = '0;
        for (int k = 0; k < WPB; k++) begin
            if ({1'b0, i_in_data.release_id[7:0]} >= 9'(k * WORD_BITS)) begin
                w_rel_w = WIDX_W'(k);
            end
        end
        w_rel_bit9 = {1'b0, i_in_data.release_id[7:0]} - 9'(w_rel_w) * 9'(WORD_BITS);
        w_rel_bad  = ({1'b0, i_in_data.release_id[15:8]} >= 9'(NUM_BUCKETS)) ||
                     ({1'b0, i_in_data.release_id[7:0]} >= 9'(WPB * WORD_BITS));
    end

    // A bucket record that was never written reads as its reset value.
    always_comb begin
        w_rec_reset.written = '0;
        w_rec_reset.nz      = '1;
        w_rec_reset.hint    = '0;
        w_rec_reset.cnt     = (r_bkt == 8'd0) ? CNT_MAX - CNT_W'(1) : CNT_MAX;
        w_rec_eff = r_rec_vld[r_bkt[BKT_W-1:0]] ? t_rec'(w_rec_rd_data) : w_rec_reset;

        w_hint_ok = ({1'b0, w_rec_eff.hint} < HINT_LIM) && w_rec_eff.nz[w_rec_eff.hint];
        w_first_w = '0;
        for (int k = WPB - 1; k >= 0; k--) begin
            if (w_rec_eff.nz[k]) begin
                w_first_w = WIDX_W'(k);
            end
        end
        if (r_op == bmida_pkg::OP_ALLOC) begin
            w_sel_w = w_hint_ok ? w_rec_eff.hint : w_first_w;
        end else begin
            w_sel_w = r_w;
        end
        w_map_rd_addr = MAP_AW'(r_bkt[BKT_W-1:0]) * MAP_AW'(WPB) + MAP_AW'(w_sel_w);
        w_map_wr_addr = MAP_AW'(r_bkt[BKT_W-1:0]) * MAP_AW'(WPB) + MAP_AW'(r_w);
    end

    // Read-modify-write of the bitmap word and the bucket record.
    always_comb begin
        if (r_rec.written[r_w]) begin
            w_word = w_map_rd_data;
        end else if (r_bkt == 8'd0 && r_w == '0) begin
            w_word = ~WORD_ONE;
        end else begin
            w_word = '1;
        end

        w_low = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w_word[i]) begin
                w_low = BIT_W'(i);
            end
        end

        w_rel_mask = WORD_ONE << r_bit;
        w_was_free = |(w_word & w_rel_mask);

        w_new_rec = r_rec;
        w_new_rec.written[r_w] = 1'b1;
        if (r_op == bmida_pkg::OP_ALLOC) begin
            w_new_word    = w_word & ~(WORD_ONE << w_low);
            w_new_rec.cnt = r_rec.cnt - CNT_W'(1);
            w_new_rec.hint = r_w;
        end else begin
            w_new_word = w_word | w_rel_mask;
            if (r_rec.cnt < CNT_MAX) begin
                w_new_rec.cnt = r_rec.cnt + CNT_W'(1);
            end
        end
        w_new_rec.nz[r_w] = |w_new_word;

        w_do_write = (r_state == S_UPD) &&
                     ((r_op == bmida_pkg::OP_ALLOC) || !w_was_free);

        w_slot = 9'(r_w) * 9'(WORD_BITS) + 9'(w_low);
        if (r_op == bmida_pkg::OP_ALLOC) begin
            w_res.status   = bmida_pkg::ST_OK;
            w_res.given_id = {r_bkt, w_slot[7:0]};
        end else begin
            w_res.status   = w_was_free ? bmida_pkg::ST_NOT_TAKEN : bmida_pkg::ST_OK;
            w_res.given_id = '0;
        end
    end

    assign w_sum_upd.en       = w_do_write;
    assign w_sum_upd.bucket   = r_bkt;
    assign w_sum_upd.has_free = (w_new_rec.cnt != '0) && (|w_new_rec.nz);

    bmida_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_BUCKETS)
    ) u_rec_ram (
        .i_clk     (i_clk),
        .i_rd_en   (r_state == S_REC),
        .i_rd_addr (r_bkt[BKT_W-1:0]),
        .o_rd_data (w_rec_rd_data),
        .i_wr_en   (w_do_write),
        .i_wr_addr (r_bkt[BKT_W-1:0]),
        .i_wr_data (REC_W'(w_new_rec))
    );

    bmida_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_rd_en   (r_state == S_MAP),
        .i_rd_addr (w_map_rd_addr),
        .o_rd_data (w_map_rd_data),
        .i_wr_en   (w_do_write),
        .i_wr_addr (w_map_wr_addr),
        .i_wr_data (w_new_word)
    );

    bmida_bsum #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_bsum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_upd         (w_sum_upd),
        .i_snap        (w_accept && i_in_data.op == bmida_pkg::OP_ALLOC),
        .i_recent      (r_recent),
        .o_recent_free (w_recent_free),
        .o_any_free    (w_any_free),
        .o_first_bkt   (w_first_bkt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_recent    <= '0;
            r_rec_vld   <= '0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op  <= i_in_data.op;
                        r_bkt <= i_in_data.release_id[15:8];
                        r_w   <= w_rel_w;
                        r_bit <= BIT_W'(w_rel_bit9);
                        if (i_in_data.op == bmida_pkg::OP_ALLOC) begin
                            r_state <= S_PICK;
                        end else if (w_rel_bad) begin
                            r_res.status   <= bmida_pkg::ST_NOT_TAKEN;
                            r_res.given_id <= '0;
                            r_state        <= S_RES;
                        end else begin
                            r_state <= S_REC;
                        end
                    end
                end
                S_PICK: begin
                    if (w_recent_free) begin
                        r_bkt   <= r_recent;
                        r_state <= S_REC;
                    end else if (w_any_free) begin
                        r_bkt   <= w_first_bkt;
                        r_state <= S_REC;
                    end else begin
                        r_res.status   <= bmida_pkg::ST_NO_FREE;
                        r_res.given_id <= '0;
                        r_state        <= S_RES;
                    end
                end
                S_REC: begin
                    r_state <= S_MAP;
                end
                S_MAP: begin
                    r_rec   <= w_rec_eff;
                    r_w     <= w_sel_w;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_do_write) begin
                        r_rec_vld[r_bkt[BKT_W-1:0]] <= 1'b1;
                    end
                    if (r_op == bmida_pkg::OP_ALLOC) begin
                        r_recent <= r_bkt;
                    end
                    if (w_out_free) begin
                        r_out   <= w_res;
                        r_state <= S_IDLE;
                    end else begin
                        r_res   <= w_res;
                        r_state <= S_RES;
                    end
                end
                S_RES: begin
                    if (w_out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // An allocate only reaches write-back on a word that still has a free bit.
    ap_alloc_word_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_op == bmida_pkg::OP_ALLOC) |-> (w_word != '0))
        else $error("allocate picked an empty bitmap word");

    // The free count of the chosen bucket agrees with the summary flags.
    ap_alloc_cnt_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_op == bmida_pkg::OP_ALLOC) |-> (r_rec.cnt != '0))
        else $error("allocate picked a bucket with zero free count");

    // A new result is only registered out of write-back or the result hold state.
    ap_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |->
            ($past(r_state) == S_UPD || $past(r_state) == S_RES))
        else $error("result appeared outside write-back");

    // Failed items never carry an ID (the design also gives releases a zero ID).
    ap_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != bmida_pkg::ST_OK) |->
            (o_out_data.given_id == '0))
        else $error("failed item carries a nonzero ID");

endmodule

`default_nettype wire

FILE: tb/id_alloc_checker.sv
// ----------------------------------------------------------------------------
// id_alloc_checker
// Watches both channels of the ID allocator, keeps its own copy of the free
// bitmaps, counts, word hints and recent bucket, predicts the result of every
// accepted request and compares it field by field with the returned beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module id_alloc_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  bmida_pkg::t_in_item  i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  bmida_pkg::t_out_item i_out_data,
    output int                   o_fail_count,
    output int                   o_outstanding
);

    localparam int NUM_BUCKETS = 256;
    localparam int WORDS       = bmida_pkg::BUCKET_IDS / 32;

    logic [31:0]                free_bits  [NUM_BUCKETS][WORDS];
    logic [bmida_pkg::CNT_W-1:0] free_cnt  [NUM_BUCKETS];
    logic [2:0]                 word_hint  [NUM_BUCKETS];
    logic [7:0]                 recent_bkt;

    bmida_pkg::t_out_item       expected_results [$];
    int                         fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic clear_free_state();
        for (int b = 0; b < NUM_BUCKETS; b++) begin
            for (int k = 0; k < WORDS; k++) begin
                free_bits[b][k] = '1;
            end
            free_cnt[b]  = bmida_pkg::CNT_W'(bmida_pkg::BUCKET_IDS);
            word_hint[b] = '0;
        end
        // ID 0 is reserved out of reset.
        free_bits[0][0][0] = 1'b0;
        free_cnt[0]        = bmida_pkg::CNT_W'(bmida_pkg::BUCKET_IDS - 1);
        recent_bkt         = '0;
    endtask

    // Takes the lowest free bit of the hinted word, or of the first nonzero
    // word when the hinted one is exhausted.
    function automatic bit take_from_bucket(input logic [7:0] b, output logic [7:0] slot);
        logic [2:0] w;
        logic [4:0] pos;
        bit         found;
        slot  = '0;
        found = 1'b0;
        w     = '0;
        if (free_cnt[b] == '0) begin
            return 1'b0;
        end
        if (free_bits[b][word_hint[b]] != '0) begin
            w     = word_hint[b];
            found = 1'b1;
        end else begin
            for (int k = 0; k < WORDS; k++) begin
                if (!found && free_bits[b][k] != '0) begin
                    w     = k[2:0];
                    found = 1'b1;
                end
            end
        end
        if (!found) begin
            return 1'b0;
        end
        pos = '0;
        while (pos < 5'd31 && !free_bits[b][w][pos]) begin
            pos++;
        end
        free_bits[b][w][pos] = 1'b0;
        word_hint[b]         = w;
        free_cnt[b]          = free_cnt[b] - 1'b1;
        slot                 = {w, pos};
        return 1'b1;
    endfunction

    function automatic bmida_pkg::t_out_item predict_id_result(input bmida_pkg::t_in_item req);
        bmida_pkg::t_out_item res;
        logic [7:0] slot;
        logic [7:0] bk;
        logic [2:0] w;
        logic [4:0] pos;
        bit         done;
        res.status   = bmida_pkg::ST_OK;
        res.given_id = '0;
        done         = 1'b0;
        if (req.op == bmida_pkg::OP_ALLOC) begin
            if (take_from_bucket(recent_bkt, slot)) begin
                res.given_id = {recent_bkt, slot};
            end else begin
                for (int b = 0; b < NUM_BUCKETS; b++) begin
                    if (!done && take_from_bucket(b[7:0], slot)) begin
                        done         = 1'b1;
                        recent_bkt   = b[7:0];
                        res.given_id = {b[7:0], slot};
                    end
                end
                if (!done) begin
                    res.status = bmida_pkg::ST_NO_FREE;
                end
            end
        end else begin
            bk  = req.release_id[15:8];
            w   = req.release_id[7:5];
            pos = req.release_id[4:0];
            if (free_bits[bk][w][pos]) begin
                res.status = bmida_pkg::ST_NOT_TAKEN;
            end else begin
                free_bits[bk][w][pos] = 1'b1;
                if (free_cnt[bk] < bmida_pkg::CNT_W'(bmida_pkg::BUCKET_IDS)) begin
                    free_cnt[bk] = free_cnt[bk] + 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("[%0t] id_alloc_checker: %s mismatch, expected %0d, got %0d",
                 $realtime, what, want, got);
        fail_total++;
    endtask

    always @(posedge i_clk) begin : watch
        bmida_pkg::t_out_item want;
        if (!i_rst_n) begin
            clear_free_state();
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result beat, status", -1,
                                    int'(i_out_data.status));
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.status !== want.status) begin
                        report_mismatch("status", int'(want.status), int'(i_out_data.status));
                    end
                    if (i_out_data.given_id !== want.given_id) begin
                        report_mismatch("given_id", int'(want.given_id),
                                        int'(i_out_data.given_id));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.insert(expected_results.size(),
                                        predict_id_result(i_in_data));
            end
        end
        o_outstanding <= expected_results.size();
    end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives allocate and release requests into the two-level bitmap ID
// allocator with random gaps and output stalls, mixes in double releases,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int  RANDOM_ITEMS = 850;
    localparam int  LONG_HOLD    = 300;
    localparam longint CYCLE_LIMIT = 300_000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 out_stall = 1'b0;
    bmida_pkg::t_in_item  in_beat   = '0;
    logic                 in_stall;
    logic                 out_valid;
    bmida_pkg::t_out_item out_beat;

    int        fail_count;
    int        outstanding;
    bit        idle_on   = 1'b0;
    bit        hold_req  = 1'b0;
    longint    cycles    = 0;

    two_level_bitmap_id_allocator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat)
    );

    id_alloc_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_beat),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_beat),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Offers one beat, possibly after an idle burst, and returns at the edge
    // where it is taken.
    task automatic send_beat(input bmida_pkg::t_op op, input logic [15:0] id);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid           <= 1'b1;
        in_beat.op         <= op;
        in_beat.release_id <= id;
        do @(posedge clk); while (in_stall);
    endtask

    // Output side: random stall bursts, plus one long hold-off that lets the
    // allocator back up into its input.
    initial begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
                out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        logic [15:0] id;
        repeat (6) @(posedge clk);
        rst_n   <= 1'b1;
        idle_on = 1'b1;
        @(posedge clk);

        // Directed: reserved ID 0, double releases, top of the ID range,
        // and the hinted word running dry within bucket 0.
        send_beat(bmida_pkg::OP_ALLOC,   16'h0000);
        send_beat(bmida_pkg::OP_ALLOC,   16'hFFFF);
        send_beat(bmida_pkg::OP_RELEASE, 16'h0000);
        send_beat(bmida_pkg::OP_RELEASE, 16'h0000);
        send_beat(bmida_pkg::OP_ALLOC,   16'h0000);
        send_beat(bmida_pkg::OP_RELEASE, 16'hFFFF);
        send_beat(bmida_pkg::OP_RELEASE, 16'h8000);
        send_beat(bmida_pkg::OP_RELEASE, 16'h0001);
        send_beat(bmida_pkg::OP_RELEASE, 16'h0001);
        send_beat(bmida_pkg::OP_ALLOC,   16'h5A5A);
        send_beat(bmida_pkg::OP_RELEASE, 16'h00FF);
        for (int i = 0; i < 34; i++) begin
            send_beat(bmida_pkg::OP_ALLOC, 16'h0000);
        end
        send_beat(bmida_pkg::OP_RELEASE, 16'h0002);
        send_beat(bmida_pkg::OP_RELEASE, 16'h0021);
        send_beat(bmida_pkg::OP_ALLOC,   16'h0000);
        send_beat(bmida_pkg::OP_ALLOC,   16'h0000);
        send_beat(bmida_pkg::OP_RELEASE, 16'h0021);

        // Random mix; releases mostly land on the low buckets in use.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 400) begin
                hold_req = 1'b1;
            end
            idle_on = !(i >= 650 && i < 760);
            if ($urandom_range(0, 99) < 55) begin
                send_beat(bmida_pkg::OP_ALLOC, 16'($urandom));
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    id = 16'($urandom);
                end else begin
                    id = 16'($urandom_range(0, 1023));
                end
                send_beat(bmida_pkg::OP_RELEASE, id);
            end
        end

        // Last part: no idling.
        idle_on = 1'b0;
        send_beat(bmida_pkg::OP_RELEASE, 16'hFFFF);
        send_beat(bmida_pkg::OP_ALLOC,   16'h0000);
        send_beat(bmida_pkg::OP_RELEASE, 16'h0000);
        send_beat(bmida_pkg::OP_ALLOC,   16'h0000);
        // Random IDs released twice in a row, each pair followed by an allocate.
        for (int i = 0; i < 40; i++) begin
            id = 16'($urandom);
            send_beat(bmida_pkg::OP_RELEASE, id);
            send_beat(bmida_pkg::OP_RELEASE, id);
            send_beat(bmida_pkg::OP_ALLOC,   16'h0000);
        end
        send_beat(bmida_pkg::OP_ALLOC, 16'h0000);

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

FILE: two_level_bitmap_id_allocator.f
design/bmida_pkg.sv
design/bmida_ram.sv
design/bmida_bsum.sv
design/two_level_bitmap_id_allocator.sv
tb/id_alloc_checker.sv
tb/tb_top.sv
